// File: hdl/kcl_pkg.sv
package kcl_pkg;

	localparam int CODE_DIGITS = 4;

	localparam int KEY_W    = 4;
	localparam int TICK_W   = 11;
	localparam int TRIES_W  = 7;
	localparam int USER_W   = 2;
	localparam int STATE_W  = 3;
	localparam int DIGS_W   = 3;
	localparam int CODE_W   = 16;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [KEY_W-1:0] KEY_BACK   = 4'd10;
	localparam logic [KEY_W-1:0] KEY_ZERO   = 4'd11;
	localparam logic [KEY_W-1:0] KEY_ENTER  = 4'd12;
	localparam logic [KEY_W-1:0] EMPTY_MARK = 4'd10;

	localparam logic [USER_W-1:0] USER_A    = 2'd0;
	localparam logic [USER_W-1:0] USER_B    = 2'd1;
	localparam logic [USER_W-1:0] USER_C    = 2'd2;
	localparam logic [USER_W-1:0] NO_USER   = 2'd3;

	localparam logic REQ_KEY  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [STATE_W-1:0] LS_RESET  = 3'd0;
	localparam logic [STATE_W-1:0] LS_ENTRY  = 3'd1;
	localparam logic [STATE_W-1:0] LS_CHECK  = 3'd2;
	localparam logic [STATE_W-1:0] LS_OPEN   = 3'd3;
	localparam logic [STATE_W-1:0] LS_DENIED = 3'd4;

	localparam logic [CODE_W-1:0]  CODE_A_RST   = 16'd9252;
	localparam logic [CODE_W-1:0]  CODE_B_RST   = 16'd12827;
	localparam logic [CODE_W-1:0]  CODE_C_RST   = 16'd26505;
	localparam logic [TICK_W-1:0]  ENTRY_TO_RST = 11'd1250;
	localparam logic [TICK_W-1:0]  HOLD_RST     = 11'd1250;
	localparam logic [TRIES_W-1:0] ALARM_RST    = 7'd4;
	localparam logic [TRIES_W-1:0] WRAP_RST     = 7'd100;

	typedef enum logic [4:0] {
		ST_RESET  = 5'b00001,
		ST_ENTRY  = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_OPEN   = 5'b01000,
		ST_DENIED = 5'b10000
	} lock_st_t;

	typedef enum logic [2:0] {
		REG_CODE_A   = 3'd0,
		REG_CODE_B   = 3'd1,
		REG_CODE_C   = 3'd2,
		REG_ENTRY_TO = 3'd3,
		REG_HOLD     = 3'd4,
		REG_ALARM    = 3'd5,
		REG_WRAP     = 3'd6
	} reg_idx_t;

	function automatic logic [STATE_W-1:0] state_code(lock_st_t st);
		logic [STATE_W-1:0] c;
		case (st)
			ST_ENTRY:  c = LS_ENTRY;
			ST_CHECK:  c = LS_CHECK;
			ST_OPEN:   c = LS_OPEN;
			ST_DENIED: c = LS_DENIED;
			default:   c = LS_RESET;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/kcl_req_if.sv
interface kcl_req_if import kcl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [KEY_W-1:0] key_code;

	modport source (output valid, req_type, key_code, input ready);
	modport sink   (input valid, req_type, key_code, output ready);
endinterface

// File: hdl/kcl_res_if.sv
interface kcl_res_if import kcl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] lock_state;
	logic               relay_on;
	logic               alarm_on;
	logic [DIGS_W-1:0]  digits_entered;
	logic [USER_W-1:0]  matched_user;
	logic [TRIES_W-1:0] wrong_try_total;

	modport source (output valid, lock_state, relay_on, alarm_on, digits_entered,
		matched_user, wrong_try_total, input ready);
	modport sink   (input valid, lock_state, relay_on, alarm_on, digits_entered,
		matched_user, wrong_try_total, output ready);
endinterface

// File: hdl/keypad_code_lock_controller.sv
// Keypad code lock. Each item on req is a key press or a timer tick; each one
// produces exactly one status item on res. One item is taken per clock cycle
// while res is not stalled: an item is captured in the input register, runs
// through the state update and lands in the result register, which drives
// res.valid. A stalled res holds the input register, and req.ready drops only
// once both are full. Registers on the APB port (4-byte stride): 0 code_a,
// 1 code_b, 2 code_c, 3 entry_timeout_ticks, 4 hold_ticks, 5 alarm_threshold,
// 6 tries_wrap. Write them only while idle.
module keypad_code_lock_controller import kcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	kcl_req_if.sink            req,
	kcl_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int CNT_W = $clog2(CODE_DIGITS + 1);
	localparam int EXT_W = 4 * CODE_DIGITS + CODE_W;

	// configuration
	logic [CODE_W-1:0]  code_a_q, code_b_q, code_c_q;
	logic [TICK_W-1:0]  entry_to_q, hold_q;
	logic [TRIES_W-1:0] alarm_thr_q, wrap_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_a_q    <= CODE_A_RST;
			code_b_q    <= CODE_B_RST;
			code_c_q    <= CODE_C_RST;
			entry_to_q  <= ENTRY_TO_RST;
			hold_q      <= HOLD_RST;
			alarm_thr_q <= ALARM_RST;
			wrap_q      <= WRAP_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_CODE_A:   code_a_q    <= pwdata[CODE_W-1:0];
				REG_CODE_B:   code_b_q    <= pwdata[CODE_W-1:0];
				REG_CODE_C:   code_c_q    <= pwdata[CODE_W-1:0];
				REG_ENTRY_TO: entry_to_q  <= pwdata[TICK_W-1:0];
				REG_HOLD:     hold_q      <= pwdata[TICK_W-1:0];
				REG_ALARM:    alarm_thr_q <= pwdata[TRIES_W-1:0];
				REG_WRAP:     wrap_q      <= pwdata[TRIES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_CODE_A:   prdata = PDATA_W'(code_a_q);
			REG_CODE_B:   prdata = PDATA_W'(code_b_q);
			REG_CODE_C:   prdata = PDATA_W'(code_c_q);
			REG_ENTRY_TO: prdata = PDATA_W'(entry_to_q);
			REG_HOLD:     prdata = PDATA_W'(hold_q);
			REG_ALARM:    prdata = PDATA_W'(alarm_thr_q);
			REG_WRAP:     prdata = PDATA_W'(wrap_q);
			default:      prdata = '0;
		endcase
	end

	// input register and handshake
	logic             valid_s1;
	logic             req_type_s1;
	logic [KEY_W-1:0] key_code_s1;
	logic             res_valid_q;
	logic             adv;
	logic             fire;

	assign adv       = !res_valid_q || res.ready;
	assign fire      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;
	assign res.valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			key_code_s1 <= req.key_code;
		end
	end

	// lock state
	lock_st_t           st_q, st_d;
	logic [KEY_W-1:0]   buf_q [CODE_DIGITS];
	logic [KEY_W-1:0]   buf_d [CODE_DIGITS];
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [TICK_W-1:0]  tick_q, tick_d, tick_inc;
	logic [TRIES_W-1:0] tries_q, tries_d, tries_inc;
	logic               relay_q, relay_d;
	logic               alarm_q, alarm_d;
	logic [USER_W-1:0]  user_q, user_d;
	logic               is_tick;
	logic               is_digit;
	logic               match_a, match_b, match_c;

	function automatic logic code_match(logic [CODE_W-1:0] code,
		logic [KEY_W-1:0] digs [CODE_DIGITS]);
		logic [EXT_W-1:0] ext;
		logic             ok;
		ext = {{(4 * CODE_DIGITS){1'b0}}, code};
		ok  = 1'b1;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (ext[4*i +: 4] != digs[i])
				ok = 1'b0;
		end
		return ok;
	endfunction

	assign is_tick   = (req_type_s1 == REQ_TICK);
	assign is_digit  = key_code_s1 inside {[4'd1:4'd9], KEY_ZERO};
	assign tick_inc  = tick_q + 1'b1;
	assign tries_inc = tries_q + 1'b1;
	assign match_a   = code_match(code_a_q, buf_q);
	assign match_b   = code_match(code_b_q, buf_q);
	assign match_c   = code_match(code_c_q, buf_q);

	always_comb begin
		st_d    = st_q;
		buf_d   = buf_q;
		cnt_d   = cnt_q;
		tick_d  = tick_q;
		tries_d = tries_q;
		relay_d = relay_q;
		alarm_d = alarm_q;
		user_d  = user_q;
		case (st_q)
			ST_ENTRY: begin
				if (!is_tick) begin
					if (key_code_s1 == KEY_ENTER) begin
						st_d = ST_CHECK;
					end else if (key_code_s1 == KEY_BACK) begin
						if (cnt_q != '0) begin
							for (int i = 0; i < CODE_DIGITS; i++) begin
								if (CNT_W'(i) == cnt_q - 1'b1)
									buf_d[i] = EMPTY_MARK;
							end
							cnt_d = cnt_q - 1'b1;
						end
					end else if (is_digit) begin
						if (cnt_q < CNT_W'(CODE_DIGITS)) begin
							for (int i = 0; i < CODE_DIGITS; i++) begin
								if (CNT_W'(i) == cnt_q)
									buf_d[i] = key_code_s1;
							end
							cnt_d = cnt_q + 1'b1;
						end
					end
					if (cnt_d == '0)
						tick_d = '0;
				end else if (cnt_q == '0) begin
					tick_d = '0;
				end else if (tick_inc >= entry_to_q) begin
					st_d    = ST_RESET;
					tick_d  = '0;
					relay_d = 1'b0;
					alarm_d = 1'b0;
					user_d  = NO_USER;
				end else begin
					tick_d = tick_inc;
				end
			end
			ST_CHECK: begin
				tick_d = '0;
				if (match_a || match_b || match_c) begin
					st_d    = ST_OPEN;
					relay_d = 1'b1;
					tries_d = '0;
					user_d  = match_a ? USER_A : (match_b ? USER_B : USER_C);
				end else begin
					st_d    = ST_DENIED;
					user_d  = NO_USER;
					tries_d = (tries_inc == wrap_q) ? '0 : tries_inc;
					if (tries_d > alarm_thr_q)
						alarm_d = 1'b1;
				end
			end
			ST_OPEN, ST_DENIED: begin
				if (is_tick) begin
					if (tick_inc >= hold_q) begin
						st_d    = ST_RESET;
						tick_d  = '0;
						relay_d = 1'b0;
						alarm_d = 1'b0;
						user_d  = NO_USER;
					end else begin
						tick_d = tick_inc;
					end
				end
			end
			default: begin
				for (int i = 0; i < CODE_DIGITS; i++)
					buf_d[i] = EMPTY_MARK;
				cnt_d  = '0;
				tick_d = '0;
				st_d   = ST_ENTRY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_RESET;
			for (int i = 0; i < CODE_DIGITS; i++)
				buf_q[i] <= EMPTY_MARK;
			cnt_q   <= '0;
			tick_q  <= '0;
			tries_q <= '0;
			relay_q <= 1'b0;
			alarm_q <= 1'b0;
			user_q  <= NO_USER;
		end else if (fire) begin
			st_q    <= st_d;
			buf_q   <= buf_d;
			cnt_q   <= cnt_d;
			tick_q  <= tick_d;
			tries_q <= tries_d;
			relay_q <= relay_d;
			alarm_q <= alarm_d;
			user_q  <= user_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res.lock_state      <= state_code(st_d);
			res.relay_on        <= relay_d;
			res.alarm_on        <= alarm_d;
			res.digits_entered  <= DIGS_W'(cnt_d);
			res.matched_user    <= user_d;
			res.wrong_try_total <= tries_d;
		end
	end

	a_relay_user: assert property (@(posedge clk) disable iff (!arst_n)
		relay_q == (user_q != NO_USER))
		else $error("relay and matched user disagree");

	a_open_relay: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_OPEN) |-> relay_q) and ((st_q == ST_DENIED) |-> !relay_q))
		else $error("relay does not follow open/denied");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CODE_DIGITS))
		else $error("digit count beyond buffer depth");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ENTRY && tick_q != '0) |-> cnt_q != '0)
		else $error("entry timer running on empty buffer");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> $stable(st_q) && $stable(tries_q))
		else $error("state advanced while result stalled");

endmodule

// File: dv/kcl_status_checker.sv
module kcl_status_checker import kcl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	kcl_req_if                 req,
	kcl_res_if                 res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 fails,
	output int                 pending
);

	localparam int DIGITS = CODE_DIGITS;

	typedef struct packed {
		logic [STATE_W-1:0] lock_state;
		logic               relay_on;
		logic               alarm_on;
		logic [DIGS_W-1:0]  digits_entered;
		logic [USER_W-1:0]  matched_user;
		logic [TRIES_W-1:0] wrong_try_total;
	} lock_status_t;

	logic [CODE_W-1:0]  cfg_code_a, cfg_code_b, cfg_code_c;
	logic [TICK_W-1:0]  cfg_entry_to, cfg_hold;
	logic [TRIES_W-1:0] cfg_alarm, cfg_wrap;

	logic [STATE_W-1:0] lk_state;
	logic [KEY_W-1:0]   dig_buf [DIGITS];
	logic [TICK_W-1:0]  tick_cnt;
	logic [TRIES_W-1:0] tries;
	logic               relay, alarm;
	logic [USER_W-1:0]  user;

	lock_status_t status_due [$];
	lock_status_t want;
	int           mism = 0;

	assign fails = mism;

	function automatic logic [DIGS_W-1:0] held_digits();
		logic [DIGS_W-1:0] n;
		n = DIGS_W'(DIGITS);
		for (int i = DIGITS - 1; i >= 0; i--)
			if (dig_buf[i] == EMPTY_MARK)
				n = DIGS_W'(i);
		return n;
	endfunction

	// nibbles above the stored code read as zero
	function automatic logic code_hit(input logic [CODE_W-1:0] code);
		logic [4*DIGITS+CODE_W-1:0] ext;
		ext = {{(4 * DIGITS){1'b0}}, code};
		for (int i = 0; i < DIGITS; i++)
			if (ext[4*i +: 4] != dig_buf[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic empty_buffer();
		for (int i = 0; i < DIGITS; i++)
			dig_buf[i] = EMPTY_MARK;
	endtask

	task automatic drop_to_reset();
		lk_state = LS_RESET;
		tick_cnt = '0;
		relay    = 1'b0;
		alarm    = 1'b0;
		user     = NO_USER;
	endtask

	task automatic step_lock(input logic is_tick, input logic [KEY_W-1:0] key,
		output lock_status_t st);
		logic [DIGS_W-1:0] n;
		case (lk_state)
			LS_ENTRY: begin
				n = held_digits();
				if (is_tick == REQ_KEY) begin
					if (key == KEY_ENTER) begin
						lk_state = LS_CHECK;
					end else if (key == KEY_BACK) begin
						if (n != 0)
							dig_buf[n - 1] = EMPTY_MARK;
					end else if ((key >= 4'd1 && key <= 4'd9) || key == KEY_ZERO) begin
						if (n < DIGITS)
							dig_buf[n] = key;
					end
					if (held_digits() == 0)
						tick_cnt = '0;
				end else if (n == 0) begin
					tick_cnt = '0;
				end else begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= cfg_entry_to)
						drop_to_reset();
				end
			end
			LS_CHECK: begin
				tick_cnt = '0;
				if (code_hit(cfg_code_a))
					user = USER_A;
				else if (code_hit(cfg_code_b))
					user = USER_B;
				else if (code_hit(cfg_code_c))
					user = USER_C;
				else
					user = NO_USER;
				if (user != NO_USER) begin
					lk_state = LS_OPEN;
					relay    = 1'b1;
					tries    = '0;
				end else begin
					lk_state = LS_DENIED;
					tries    = tries + 1'b1;
					if (tries == cfg_wrap)
						tries = '0;
					if (tries > cfg_alarm)
						alarm = 1'b1;
				end
			end
			LS_OPEN, LS_DENIED: begin
				if (is_tick == REQ_TICK) begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= cfg_hold)
						drop_to_reset();
				end
			end
			default: begin
				empty_buffer();
				tick_cnt = '0;
				lk_state = LS_ENTRY;
			end
		endcase
		st.lock_state      = lk_state;
		st.relay_on        = relay;
		st.alarm_on        = alarm;
		st.digits_entered  = held_digits();
		st.matched_user    = user;
		st.wrong_try_total = tries;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want_v, got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mism++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_code_a   = CODE_A_RST;
			cfg_code_b   = CODE_B_RST;
			cfg_code_c   = CODE_C_RST;
			cfg_entry_to = ENTRY_TO_RST;
			cfg_hold     = HOLD_RST;
			cfg_alarm    = ALARM_RST;
			cfg_wrap     = WRAP_RST;
			empty_buffer();
			tries = '0;
			drop_to_reset();
			status_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_CODE_A:   cfg_code_a   = pwdata[CODE_W-1:0];
					REG_CODE_B:   cfg_code_b   = pwdata[CODE_W-1:0];
					REG_CODE_C:   cfg_code_c   = pwdata[CODE_W-1:0];
					REG_ENTRY_TO: cfg_entry_to = pwdata[TICK_W-1:0];
					REG_HOLD:     cfg_hold     = pwdata[TICK_W-1:0];
					REG_ALARM:    cfg_alarm    = pwdata[TRIES_W-1:0];
					REG_WRAP:     cfg_wrap     = pwdata[TRIES_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (status_due.size() == 0) begin
					$error("status item with nothing expected");
					mism++;
				end else begin
					want = status_due.pop_front();
					cmp_field("lock_state", 32'(want.lock_state), 32'(res.lock_state));
					cmp_field("relay_on", 32'(want.relay_on), 32'(res.relay_on));
					cmp_field("alarm_on", 32'(want.alarm_on), 32'(res.alarm_on));
					cmp_field("digits_entered", 32'(want.digits_entered),
						32'(res.digits_entered));
					cmp_field("matched_user", 32'(want.matched_user), 32'(res.matched_user));
					cmp_field("wrong_try_total", 32'(want.wrong_try_total),
						32'(res.wrong_try_total));
				end
			end
			if (req.valid && req.ready) begin
				step_lock(req.req_type, req.key_code, want);
				status_due.push_back(want);
			end
			pending <= status_due.size();
		end
	end

endmodule

// File: dv/keypad_code_lock_controller_tb.sv
module keypad_code_lock_controller_tb;
	import kcl_pkg::*;

	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 98;
	localparam int LAST_ITEMS  = 40;
	localparam int SQUEEZE     = 300;
	localparam int QUIET_LIMIT = 3000;

	typedef enum int {CODE_FULL, CODE_PREFIX, CODE_ANY} code_style_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 fails, pending;

	kcl_req_if req_ch ();
	kcl_res_if res_ch ();

	keypad_code_lock_controller DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	kcl_status_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	int                n_items = 0, n_keys = 0, n_ticks = 0, n_settings = 0;
	int                burst_left = 0;
	int                quiet = 0;
	int                cur_hold;
	logic [CODE_W-1:0] cur_code [3];

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: changing stall patterns, one long hold-off to back up the input
	initial begin
		int mode, left, cyc;
		bit squeeze_done;
		mode = 0;
		left = 0;
		cyc = 0;
		squeeze_done = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!squeeze_done && n_items >= 400) begin
				squeeze_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (SQUEEZE) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 80);
			end
			left--;
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= (cyc % 5) != 0;
			endcase
		end
	end

	task automatic send_event(input logic is_tick, input logic [KEY_W-1:0] key);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= is_tick;
		req_ch.key_code <= key;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		n_items++;
		if (is_tick == REQ_TICK)
			n_ticks++;
		else
			n_keys++;
	endtask

	task automatic send_key(input logic [KEY_W-1:0] key);
		send_event(REQ_KEY, key);
	endtask

	task automatic send_tick();
		send_event(REQ_TICK, 4'($urandom_range(1, 12)));
	endtask

	function automatic logic [KEY_W-1:0] random_digit();
		logic [KEY_W-1:0] d;
		d = 4'($urandom_range(1, 10));
		if (d == KEY_BACK)
			d = KEY_ZERO;
		return d;
	endfunction

	function automatic logic [CODE_W-1:0] make_code(input code_style_t style);
		logic [CODE_W-1:0] c;
		int len;
		len = $urandom_range(0, 3);
		c = 16'($urandom);
		if (style != CODE_ANY)
			for (int i = 0; i < 4; i++)
				c[4*i +: 4] = (style == CODE_FULL || i < len) ? random_digit() : EMPTY_MARK;
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] any_code();
		int r;
		r = $urandom_range(0, 5);
		return make_code(r < 4 ? CODE_FULL : (r == 4 ? CODE_PREFIX : CODE_ANY));
	endfunction

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CODE_W-1:0] ca, cb, cc,
		input int entry_to, hold, alarm_th, wrap);
		settle();
		apb_write(REG_CODE_A, {16'($urandom), ca});
		apb_write(REG_CODE_B, {16'($urandom), cb});
		apb_write(REG_CODE_C, {16'($urandom), cc});
		apb_write(REG_ENTRY_TO, {21'($urandom), 11'(entry_to)});
		apb_write(REG_HOLD, {21'($urandom), 11'(hold)});
		apb_write(REG_ALARM, {25'($urandom), 7'(alarm_th)});
		apb_write(REG_WRAP, {25'($urandom), 7'(wrap)});
		cur_code[0] = ca;
		cur_code[1] = cb;
		cur_code[2] = cc;
		cur_hold    = hold;
		n_settings++;
	endtask

	// one attempt at a code: stored or random, with slips, then the check and the hold
	task automatic try_code();
		logic [CODE_W-1:0] code;
		logic [KEY_W-1:0]  nib;
		int sel, n_t;
		sel = $urandom_range(0, 3);
		code = (sel < 3) ? cur_code[sel] : make_code(CODE_FULL);
		send_tick();
		repeat ($urandom_range(0, 4)) send_key(KEY_BACK);
		for (int i = 0; i < 4; i++) begin
			nib = code[4*i +: 4];
			if (nib == EMPTY_MARK)
				break;
			if ($urandom_range(0, 9) == 0) begin
				send_key(random_digit());
				send_key(KEY_BACK);
			end
			if ($urandom_range(0, 15) == 0)
				send_tick();
			send_key(((nib >= 4'd1 && nib <= 4'd9) || nib == KEY_ZERO) ? nib : random_digit());
		end
		if ($urandom_range(0, 5) == 0)
			send_key(random_digit());
		send_key(KEY_ENTER);
		send_event(1'($urandom_range(0, 1)), 4'($urandom_range(1, 12)));
		n_t = cur_hold + $urandom_range(0, 1);
		if (n_t > 40)
			n_t = 40;
		repeat (n_t) send_tick();
	endtask

	task automatic send_noise();
		if ($urandom_range(0, 2) == 0)
			send_tick();
		else
			send_key(4'($urandom_range(1, 12)));
	endtask

	initial begin
		int start, target;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_KEY;
		req_ch.key_code <= KEY_ENTER;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		cur_code[0] = CODE_A_RST;
		cur_code[1] = CODE_B_RST;
		cur_code[2] = CODE_C_RST;
		cur_hold    = HOLD_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: wake, empty backspace, first stored code with a full-buffer drop
		send_tick();
		send_key(KEY_BACK);
		send_tick();
		send_key(4'd4);
		send_key(4'd2);
		send_key(4'd4);
		send_key(4'd2);
		send_key(4'd9);
		send_key(KEY_BACK);
		send_key(4'd2);
		send_key(KEY_ENTER);
		send_key(4'd7);
		send_key(4'd5);
		send_tick();

		// short timeouts, unmatchable code, prefix code that matches empty positions
		apply_settings(16'h0000, CODE_B_RST, 16'hAAA5, 3, 2, 0, 2);
		send_tick();
		send_key(4'd3);
		send_key(4'd1);
		repeat (3) send_tick();
		send_key(KEY_ENTER);
		send_key(KEY_ENTER);
		send_tick();
		repeat (3) send_tick();
		send_key(4'd5);
		send_key(KEY_ENTER);
		send_key(KEY_ZERO);

		for (int p = 0; p < N_PHASES; p++) begin
			target = PHASE_ITEMS;
			if (p == 0)
				apply_settings(16'hFFFF, make_code(CODE_FULL), make_code(CODE_PREFIX),
					1, 1, 0, 1);
			else if (p == 1)
				apply_settings(make_code(CODE_FULL), make_code(CODE_PREFIX),
					make_code(CODE_FULL), 2047, $urandom_range(1, 4), 127, 127);
			else if (p == N_PHASES - 1) begin
				target = LAST_ITEMS;
				apply_settings(make_code(CODE_FULL), make_code(CODE_PREFIX),
					make_code(CODE_ANY), 2047, 2047, 127, 127);
			end else
				apply_settings(any_code(), any_code(), any_code(), $urandom_range(1, 16),
					$urandom_range(1, 5), $urandom_range(0, 8),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 127)
						: $urandom_range(1, 10));
			start = n_items;
			while (n_items - start < target) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 6)) send_noise();
				else
					try_code();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Sent %0d items (%0d key presses, %0d ticks) under %0d register settings,",
			n_items, n_keys, n_ticks, n_settings);
		$display("with random output stalls and one %0d-cycle hold-off.", SQUEEZE);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
